/* hw/rtl/mec_pkg.sv */
// Shared types, constants and saturation helper for the escape-time counter.
// No dependencies; every other file in hw/rtl imports this package.
package mec_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_ITER    = 256;
  localparam int FRAC_BITS   = 28;
  localparam int FIELD_W     = 12;
  localparam int ITER_W      = 9;
  localparam int IDX_W       = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int CNT_W       = $clog2(MAX_ITER + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SAT_W       = 48;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -48'sd2147483648;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ORIGIN_REAL = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IMAG = 2'd1;
  localparam logic [1:0] REG_STEP_REAL   = 2'd2;
  localparam logic [1:0] REG_STEP_IMAG   = 2'd3;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cpoint_t;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;
  } mec_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD
  } bk_state_t;

  typedef struct packed {
    bk_state_t        state;
    logic [CNT_W-1:0] count;
  } bk_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[31:0]);
    end
  endfunction

endpackage

/* hw/rtl/mec_front.sv */
// Front end: accepts pixel coordinates and forms the point c from the
// configured origin and step. Depends on mec_pkg.
module mec_front import mec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,
  input  mec_cfg_t             cfg,
  input  logic                 q_full,
  output logic                 push,
  output cpoint_t              point
);

  logic [IDX_W-1:0]       idx_re;
  logic [IDX_W-1:0]       idx_im;
  logic [IDX_W+30:0]      prod_re;
  logic [IDX_W+30:0]      prod_im;
  logic signed [SAT_W-1:0] sum_re;
  logic signed [SAT_W-1:0] sum_im;
  logic                   ready_r;

  // Ready is a register, held low in reset and set once reset is released;
  // from then on the input is refused only while the queue is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign in_tready = ready_r & ~q_full;
  assign push      = in_tvalid & in_tready;

  assign idx_re  = in_tdata[IDX_W-1:0];
  assign idx_im  = in_tdata[FIELD_W+IDX_W-1:FIELD_W];
  assign prod_re = idx_re * cfg.step_re;
  assign prod_im = idx_im * cfg.step_im;
  assign sum_re  = SAT_W'(cfg.origin_re) + signed'(SAT_W'(prod_re));
  assign sum_im  = SAT_W'(cfg.origin_im) + signed'(SAT_W'(prod_im));

  assign point.re = sat32(sum_re);
  assign point.im = sat32(sum_im);

endmodule

/* hw/rtl/mec_queue.sv */
// Short queue of points between the front end and the iteration engine.
// Depends on mec_pkg.
module mec_queue import mec_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cpoint_t wr_point,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output cpoint_t rd_point
);

  cpoint_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_point  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mec_back.sv */
// Iteration engine: runs z = z^2 + c for one point at a time and holds the
// count in an output register. Depends on mec_pkg.
module mec_back import mec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  cpoint_t           q_point,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ITER_W-1:0] out_iter,
  output bk_status_t        status
);

  bk_state_t               state_r;
  bk_state_t               state_nxt;
  logic signed [31:0]      cr_r;
  logic signed [31:0]      ci_r;
  logic signed [31:0]      zr_r;
  logic signed [31:0]      zi_r;
  logic signed [63:0]      rr_r;
  logic signed [63:0]      ii_r;
  logic signed [63:0]      ri_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_valid_r;
  logic [ITER_W-1:0]       out_iter_r;

  logic signed [63:0]      rr_p;
  logic signed [63:0]      ii_p;
  logic signed [63:0]      ri_p;
  logic [63:0]             mag;
  logic signed [63:0]      diff;
  logic signed [SAT_W-1:0] nr_sum;
  logic signed [SAT_W-1:0] ni_sum;
  logic                    finish;
  logic                    out_free;
  logic                    load_out;
  logic                    step_z;

  // Products of the current z; registered before they are used
  assign rr_p = zr_r * zr_r;
  assign ii_p = zi_r * zi_r;
  assign ri_p = zr_r * zi_r;

  // The products also give |z|^2 for the escape test on the last update
  assign mag      = $unsigned(rr_r) + $unsigned(ii_r);
  assign finish   = (count_r != '0) &&
                    ((mag[63:58] != '0) || (count_r == CNT_W'(MAX_ITER)));
  assign out_free = ~out_valid_r | out_tready;

  assign diff   = rr_r - ii_r;
  assign nr_sum = SAT_W'(diff >>> FRAC_BITS) + SAT_W'(cr_r);
  assign ni_sum = SAT_W'(ri_r >>> (FRAC_BITS - 1)) + SAT_W'(ci_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_not_empty) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        state_nxt = BK_UPD;
      end
      BK_UPD: begin
        if (!finish) begin
          state_nxt = BK_MUL;
        end else if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    step_z   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop = q_not_empty;
      end
      BK_UPD: begin
        load_out = finish & out_free;
        step_z   = ~finish;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cr_r <= q_point.re;
      ci_r <= q_point.im;
      zr_r <= '0;
      zi_r <= '0;
    end else if (step_z) begin
      zr_r <= sat32(nr_sum);
      zi_r <= sat32(ni_sum);
    end
    if (state_r == BK_MUL) begin
      rr_r <= rr_p;
      ii_r <= ii_p;
      ri_r <= ri_p;
    end
    if (load_out) begin
      out_iter_r <= ITER_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        count_r <= '0;
      end else if (step_z) begin
        count_r <= count_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_iter     = out_iter_r;
  assign status.state = state_r;
  assign status.count = count_r;

endmodule

/* hw/rtl/mandelbrot_escape_counter.sv */
// Top level of the escape-time counter: configuration registers, front end,
// point queue and iteration engine. Depends on mec_pkg, mec_front, mec_queue, mec_back.
//
// Usage. Each transfer on the in_ channel carries one pixel: the column in
// in_tdata[11:0] and the global row in in_tdata[23:12]. The front end forms
// c = origin + index * step (saturated to signed Q4.28) in the cycle of the
// transfer and writes it into a two-entry queue. The iteration engine takes
// points from the queue one at a time and iterates z = z^2 + c from zero:
// a product step forms the three 32x32 products of z, and the update step
// that follows applies the update and checks |z|^2 >= 4 on the products of
// the previous update. Iteration ends on escape or at the limit of 256
// iterations; the iteration loop sets the throughput.
// The count (1 to 256) leaves on the out_ channel from an output register.
// While the receiver stalls, the result is held, the engine starts on the
// next queued point and the input keeps accepting until the queue is full.
// Reset (synchronous, active low) empties the queue and the engine and loads
// origin -2.0 - 2.0i and steps of 2^-10. The user must write the registers through
// the APB-style port only while the block is idle; the block does not enforce it.
module mandelbrot_escape_counter import mec_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,   // [11:0] column, [23:12] line
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [8:0] iterations, [15:9] zero
  // configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  mec_cfg_t          cfg_r;
  logic              cfg_wr;
  logic              q_full;
  logic              q_not_empty;
  logic              push;
  logic              pop;
  cpoint_t           front_point;
  cpoint_t           q_point;
  logic [ITER_W-1:0] out_iter;
  bk_status_t        bk_status;

  // Configuration registers. The register index is the word address; the
  // byte offset bits are ignored. Bits above a register's width are dropped.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= -32'sd536870912;
      cfg_r.origin_im <= -32'sd536870912;
      cfg_r.step_re   <= 31'd262144;
      cfg_r.step_im   <= 31'd262144;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ORIGIN_REAL: cfg_r.origin_re <= signed'(cfg_pwdata);
        REG_ORIGIN_IMAG: cfg_r.origin_im <= signed'(cfg_pwdata);
        REG_STEP_REAL:   cfg_r.step_re   <= cfg_pwdata[30:0];
        REG_STEP_IMAG:   cfg_r.step_im   <= cfg_pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ORIGIN_REAL: cfg_prdata = cfg_r.origin_re;
      REG_ORIGIN_IMAG: cfg_prdata = cfg_r.origin_im;
      REG_STEP_REAL:   cfg_prdata = {1'b0, cfg_r.step_re};
      REG_STEP_IMAG:   cfg_prdata = {1'b0, cfg_r.step_im};
      default:         cfg_prdata = '0;
    endcase
  end

  // The front end only scales and offsets; all iteration happens behind the
  // queue, so a long-running pixel blocks input only once the queue is full.
  mec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .point     (front_point)
  );

  mec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_point  (front_point),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_point  (q_point)
  );

  mec_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_point     (q_point),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_iter    (out_iter),
    .status      (bk_status)
  );

  assign out_tdata = {{(16 - ITER_W){1'b0}}, out_iter};

  // The update step always follows a product step, never a fresh load.
  a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.state == BK_IDLE |=> bk_status.state != BK_UPD)
    else $error("update step entered straight from idle");

  // The iteration count never passes the limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.count <= CNT_W'(MAX_ITER))
    else $error("iteration count beyond the limit");

  // A new result is only raised from the update step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bk_status.state) == BK_UPD)
    else $error("result raised outside the update step");

  // A point is never taken from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_not_empty)
    else $error("queue read while empty");

endmodule

/* bench/mandelbrot_escape_counter_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the Mandelbrot escape-time counter: random and directed
// pixels against a fixed-point escape predictor. Needs mec_pkg and the counter RTL.
module mandelbrot_escape_counter_tb;
  import mec_pkg::*;

  // One pixel as it travels on in_tdata: column in the low bits, row above it.
  typedef struct packed {
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] column;
  } pixel_t;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  // |z|^2 limit of 4.0 in Q8.56.
  localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;
  // Longest a single pixel may take, plus some slack, for the tail of the run.
  localparam int DRAIN_CYCLES = 2 * MAX_ITER + 16;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [2*FIELD_W-1:0] in_tdata = '0;    // [11:0] column, [23:12] line
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;        // [8:0] iterations, [15:9] zero
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [3:0]           cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  mandelbrot_escape_counter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // The bench keeps its own copy of the view registers. They only change while
  // the counter is idle, so a prediction made at the input transfer is safe.
  longint view_origin_re = -64'sd536870912;
  longint view_origin_im = -64'sd536870912;
  longint view_step_re   = 64'sd262144;
  longint view_step_im   = 64'sd262144;

  pixel_t            pending_pixels[$];
  logic [ITER_W-1:0] expected_counts[$];

  int mismatches     = 0;
  int pixels_sent    = 0;
  int results_seen   = 0;
  int capped_results = 0;
  int first_escapes  = 0;
  int settings_used  = 1;

  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Escape-time iteration in Q4.28. The arithmetic shift of a signed longint
  // rounds towards minus infinity, which is exactly the rounding wanted here.
  // The imaginary product is shifted one place less to fold in the factor 2.
  function automatic logic [ITER_W-1:0] escape_count(input pixel_t p);
    longint      col;
    longint      row;
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      nr;
    longint      ni;
    logic [63:0] mag;
    int          n;
    col = longint'(p.column) & ((64'sd1 <<< COORD_BITS) - 1);
    row = longint'(p.row) & ((64'sd1 <<< COORD_BITS) - 1);
    cr  = clamp_q428(view_origin_re + col * view_step_re);
    ci  = clamp_q428(view_origin_im + row * view_step_im);
    zr  = 0;
    zi  = 0;
    n   = 0;
    do begin
      nr = clamp_q428(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      // Each square is at most 2^62, so the unsigned sum cannot wrap.
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      n++;
    end while (mag < ESCAPE_Q56 && n < MAX_ITER);
    return n[ITER_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s: expected %0d, got %0d (tdata 0x%04h)", $realtime, what,
               want, got[ITER_W-1:0], got);
    end
  endtask

  // ------------------------------------------------------------------------
  // Pixel driver. After every transfer it draws a random gap before the next
  // pixel, and now and then switches into a calm stretch where pixels follow
  // back to back. The expected count is worked out at the transfer itself.
  // ------------------------------------------------------------------------
  pixel_t pixel_on_bus = '0;
  int     in_gap = 0;
  bit     in_calm = 1'b0;

  always @(posedge clk) begin : drive_pixels
    logic vld_next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      vld_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_counts.push_back(escape_count(pixel_on_bus));
        pixels_sent++;
        vld_next = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 13);
      end
      if (!vld_next) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending_pixels.size() != 0) begin
          pixel_on_bus = pending_pixels.pop_front();
          in_tdata <= pixel_on_bus;
          vld_next = 1'b1;
        end
      end
      in_tvalid <= vld_next;
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor. Every transfer on out_ is checked against the oldest
  // expected count; the padding bits above the count must read as zero. After
  // each transfer the receiver draws a random stall, which is zero in a calm stretch.
  // ------------------------------------------------------------------------
  int out_stall = 0;
  bit out_calm = 1'b0;

  always @(posedge clk) begin : take_results
    logic              rdy_next;
    logic [ITER_W-1:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      rdy_next = out_tready;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tdata[ITER_W-1:0] == ITER_W'(MAX_ITER)) capped_results++;
        if (out_tdata[ITER_W-1:0] == ITER_W'(1)) first_escapes++;
        if (expected_counts.size() == 0) begin
          note_mismatch("result with no pixel outstanding", '0, out_tdata);
        end else begin
          want = expected_counts.pop_front();
          if (out_tdata !== 16'(want)) note_mismatch("iteration count", 16'(want), out_tdata);
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 13);
        rdy_next = (out_stall == 0);
      end else if (!out_tready) begin
        if (out_stall != 0) out_stall--;
        rdy_next = (out_stall == 0);
      end
      out_tready <= rdy_next;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers.
  // ------------------------------------------------------------------------
  task automatic queue_pixel(input int col, input int row);
    pixel_t p;
    p.column = col[FIELD_W-1:0];
    p.row    = row[FIELD_W-1:0];
    pending_pixels.push_back(p);
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // Waits until every queued pixel has been sent and every result has come back.
  // The check runs on the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_tvalid || expected_counts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready completes it.
  // The bench copy of the register is updated as the write completes.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ORIGIN_REAL: view_origin_re = longint'(signed'(value));
      REG_ORIGIN_IMAG: view_origin_im = longint'(signed'(value));
      REG_STEP_REAL:   view_step_re   = longint'(value[30:0]);
      REG_STEP_IMAG:   view_step_im   = longint'(value[30:0]);
      default: ;
    endcase
  endtask

  // Loads a new view once the counter has gone idle. The step registers are
  // only 31 bits wide, so a set bit 31 in the write data must be ignored.
  task automatic apply_view(input logic [31:0] origin_re, input logic [31:0] origin_im,
                            input logic [31:0] step_re, input logic [31:0] step_im);
    wait_drained();
    reg_write(REG_ORIGIN_REAL, origin_re);
    reg_write(REG_ORIGIN_IMAG, origin_im);
    reg_write(REG_STEP_REAL, step_re);
    reg_write(REG_STEP_IMAG, step_im);
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Test sequence.
  // ------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view: origin -2 - 2i, step 2^-10, so the image spans [-2, 2] on
    // both axes and column or row 2048 lands on zero.
    queue_pixel(0, 0);              // far corner, escapes on the first step
    queue_pixel(4095, 4095);
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 2048);           // c = -2: |z|^2 sits exactly on 4
    queue_pixel(2048, 2048);        // c = 0, runs to the limit
    queue_pixel(1024, 2048);        // c = -1, period-two orbit
    queue_pixel(2304, 2048);        // c = 0.25, cusp of the main cardioid
    queue_pixel(2048, 3072);        // c = i, bounded pre-periodic orbit
    queue_pixel(2048, 1024);        // c = -i
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    queue_pixel(1700, 2600);
    queue_pixel(4095, 2048);
    queue_random(376);

    // Zoom on the neck of the set near -0.75 + 0.1i, where counts vary widely.
    apply_view(-32'sd214748365, 32'sd13421773, 32'd6554, 32'd6554);
    queue_random(150);

    // Extreme registers: points far beyond the Q4.28 range saturate.
    apply_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_random(26);

    apply_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_random(26);

    // Zero origin and zero steps: every pixel is c = 0 and hits the limit.
    apply_view(32'h0, 32'h0, 32'h0, 32'h0);
    queue_random(10);

    // Random views over the interesting region with a range of zoom levels.
    repeat (5) begin
      apply_view(32'($urandom_range(0, 32'h4000_0000)) - 32'd671088640,
                 32'($urandom_range(0, 32'h4000_0000)) - 32'd536870912,
                 32'($urandom_range(256, 262144)) | {$urandom_range(0, 1) == 1, 31'b0},
                 32'($urandom_range(256, 262144)) | {$urandom_range(0, 1) == 1, 31'b0});
      queue_random(60);
    end

    // Fully random register contents, mostly saturated points.
    apply_view($urandom, $urandom, $urandom, $urandom);
    queue_random(40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pixels over %0d views, from saturated corners to the zoomed neck.",
             pixels_sent, settings_used);
    $display("%0d of %0d results reached the iteration limit, %0d escaped on the first step.",
             capped_results, results_seen, first_escapes);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", mismatches,
               expected_counts.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: well beyond a run in which every pixel needs all 256 iterations.
  initial begin : watchdog
    #30_000_000;
    $display("Timed out with %0d pixels queued and %0d results outstanding",
             pending_pixels.size(), expected_counts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mec_pkg.sv
hw/rtl/mec_front.sv
hw/rtl/mec_queue.sv
hw/rtl/mec_back.sv
hw/rtl/mandelbrot_escape_counter.sv
bench/mandelbrot_escape_counter_tb.sv
